// ===== hdl/i2cm_pkg.sv =====
// Package for the I2C master byte engine: command kinds, sizes and the
// records that travel between the front end, the queue and the bit engine.
// Depends on nothing.
package i2cm_pkg;

	// Command codes as they arrive on the action field.
	typedef enum logic [1:0] {
		K_START = 2'd0,
		K_STOP  = 2'd1,
		K_WRITE = 2'd2,
		K_READ  = 2'd3
	} kind_t;

	localparam int PT_W            = 11;    // width of the phase length register
	localparam int TICK_W          = 10;    // width of the tick counter
	localparam int BIT_W           = 4;     // width of the bit slot counter
	localparam int MAX_PHASE_TICKS = 1024;
	localparam int RESET_TICKS     = 10;
	localparam logic [BIT_W-1:0] ACK_SLOT = 4'd8;
	localparam logic [BIT_W-1:0] LAST_BIT = 4'd7;

	// Queue between the front end and the bit engine.
	localparam int QDEPTH = 4;
	localparam int QPTR_W = $clog2(QDEPTH);
	localparam int QCNT_W = $clog2(QDEPTH + 1);

	// One decoded tick request.
	typedef struct packed {
		logic       cmd_valid;
		kind_t      kind;
		logic [7:0] tx_byte;
		logic       send_ack;
		logic       sda_in;
	} q_entry_t;

	// Queue status seen by both neighbors.
	typedef struct packed {
		logic full;
		logic empty;
	} q_stat_t;

endpackage

// ===== hdl/i2cm_if.sv =====
// Handshake channels of the I2C master byte engine: tick requests, results
// and the phase length write port. Depends on i2cm_pkg.
interface i2cm_tick_if;
	logic       valid;
	logic       ready;
	logic       cmd_valid;
	logic [1:0] action;
	logic [7:0] tx_byte;
	logic       send_ack;
	logic       sda_in;

	modport source (output valid, cmd_valid, action, tx_byte, send_ack, sda_in,
		input ready);
	modport sink (input valid, cmd_valid, action, tx_byte, send_ack, sda_in,
		output ready);
endinterface

interface i2cm_res_if;
	logic       valid;
	logic       ready;
	logic       scl_out;
	logic       sda_out;
	logic       busy_res;
	logic       done_res;
	logic [7:0] rx_byte;
	logic       ack_missing;

	modport source (output valid, scl_out, sda_out, busy_res, done_res, rx_byte,
		ack_missing, input ready);
	modport sink (input valid, scl_out, sda_out, busy_res, done_res, rx_byte,
		ack_missing, output ready);
endinterface

interface i2cm_cfg_if;
	logic                      valid;
	logic                      ready;
	logic [i2cm_pkg::PT_W-1:0] data;

	modport source (output valid, data, input ready);
	modport sink (input valid, data, output ready);
endinterface

// ===== hdl/i2cm_front.sv =====
// Front end: takes tick requests, decodes the action into a command kind
// and hands the record to the queue. Depends on i2cm_pkg and i2cm_if.
module i2cm_front (
	input  logic                clk,
	input  logic                arst_n,
	i2cm_tick_if.sink           tick,
	input  i2cm_pkg::q_stat_t   qstat,
	output logic                push,
	output i2cm_pkg::q_entry_t  entry
);
	logic               vld_s1;
	i2cm_pkg::q_entry_t entry_s1;

	assign push       = vld_s1 && !qstat.full;
	assign tick.ready = !vld_s1 || !qstat.full;
	assign entry      = entry_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (tick.valid && tick.ready) begin
			vld_s1 <= 1'b1;
		end else if (push) begin
			vld_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (tick.valid && tick.ready) begin
			entry_s1.cmd_valid <= tick.cmd_valid;
			entry_s1.kind      <= i2cm_pkg::kind_t'(tick.action);
			entry_s1.tx_byte   <= tick.tx_byte;
			entry_s1.send_ack  <= tick.send_ack;
			entry_s1.sda_in    <= tick.sda_in;
		end
	end

endmodule

// ===== hdl/i2cm_queue.sv =====
// Short queue of decoded tick requests between the front end and the bit
// engine. Depends on i2cm_pkg.
module i2cm_queue (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                push,
	input  i2cm_pkg::q_entry_t  push_entry,
	input  logic                pop,
	output i2cm_pkg::q_entry_t  head,
	output i2cm_pkg::q_stat_t   qstat
);
	i2cm_pkg::q_entry_t               slot_q [i2cm_pkg::QDEPTH];
	logic [i2cm_pkg::QPTR_W-1:0]      wr_ptr_q;
	logic [i2cm_pkg::QPTR_W-1:0]      rd_ptr_q;
	logic [i2cm_pkg::QCNT_W-1:0]      count_q;

	assign qstat.full  = (count_q == i2cm_pkg::QCNT_W'(i2cm_pkg::QDEPTH));
	assign qstat.empty = (count_q == '0);
	assign head        = slot_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= push_entry;
		end
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		!(push && qstat.full)) else $error("queue written while full");
	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		!(pop && qstat.empty)) else $error("queue read while empty");
	a_count_track: assert property (@(posedge clk) disable iff (!arst_n)
		(push && !pop) |=> count_q == $past(count_q) + 1'b1)
		else $error("queue count lost a write");

endmodule

// ===== hdl/i2cm_engine.sv =====
// Bit engine: advances the bus sequencer by one tick request per cycle while one is queued
// and its result is not stalled, and holds the result in the output register. Depends on i2cm_pkg and i2cm_if.
module i2cm_engine (
	input  logic                         clk,
	input  logic                         arst_n,
	input  i2cm_pkg::q_entry_t           head,
	input  i2cm_pkg::q_stat_t            qstat,
	input  logic [i2cm_pkg::TICK_W-1:0]  last_tick,
	output logic                         pop,
	i2cm_res_if.source                   res
);
	i2cm_pkg::kind_t                kind_q, n_kind;
	logic                           run_q, n_run;
	logic [i2cm_pkg::BIT_W-1:0]     bit_q, n_bit;
	logic [1:0]                     ph_q, n_ph;
	logic [i2cm_pkg::TICK_W-1:0]    tick_q, n_tick;
	logic [7:0]                     sout_q, n_sout;
	logic [7:0]                     sin_q, n_sin;
	logic                           ack_q, n_ack;
	logic                           scl_q, n_scl;
	logic                           sda_q, n_sda;
	logic                           want_q, n_want;
	logic                           done_q, n_done;
	logic                           res_vld_q;
	logic                           do_enter;
	logic [1:0]                     last_ph;
	logic [i2cm_pkg::BIT_W-1:0]     final_bit;

	assign pop = !qstat.empty && (!res_vld_q || res.ready);

	// Last phase index and last bit slot of the running command.
	always_comb begin
		if (kind_q == i2cm_pkg::K_STOP) begin
			last_ph = 2'd1;
		end else if (kind_q == i2cm_pkg::K_READ && bit_q < i2cm_pkg::ACK_SLOT) begin
			last_ph = 2'd1;
		end else begin
			last_ph = 2'd2;
		end
		if (kind_q == i2cm_pkg::K_START || kind_q == i2cm_pkg::K_STOP) begin
			final_bit = '0;
		end else begin
			final_bit = i2cm_pkg::ACK_SLOT;
		end
	end

	always_comb begin
		n_kind   = kind_q;
		n_run    = run_q;
		n_bit    = bit_q;
		n_ph     = ph_q;
		n_tick   = tick_q;
		n_sout   = sout_q;
		n_sin    = sin_q;
		n_ack    = ack_q;
		n_scl    = scl_q;
		n_sda    = sda_q;
		n_want   = want_q;
		n_done   = 1'b0;
		do_enter = 1'b0;

		if (pop) begin
			if (!run_q) begin
				if (head.cmd_valid) begin
					n_kind   = head.kind;
					n_run    = 1'b1;
					n_bit    = '0;
					n_ph     = '0;
					n_tick   = '0;
					n_sout   = head.tx_byte;
					n_want   = head.send_ack;
					if (head.kind == i2cm_pkg::K_READ) begin
						n_sin = '0;
					end
					do_enter = 1'b1;
				end
			end else if (tick_q < last_tick) begin
				n_tick = tick_q + 1'b1;
			end else begin
				// Sample on the last tick of the SCL high phase.
				if (kind_q == i2cm_pkg::K_WRITE && bit_q == i2cm_pkg::ACK_SLOT
					&& ph_q == 2'd1) begin
					n_ack = head.sda_in;
				end else if (kind_q == i2cm_pkg::K_READ
					&& bit_q < i2cm_pkg::ACK_SLOT && ph_q == 2'd0) begin
					n_sin = {sin_q[6:0], head.sda_in};
				end
				n_tick = '0;
				if (ph_q < last_ph) begin
					n_ph     = ph_q + 1'b1;
					do_enter = 1'b1;
				end else if (bit_q < final_bit) begin
					n_bit    = bit_q + 1'b1;
					n_ph     = '0;
					do_enter = 1'b1;
				end else begin
					n_run  = 1'b0;
					n_done = 1'b1;
					if (kind_q == i2cm_pkg::K_READ) begin
						n_sda = 1'b1;
					end
				end
			end
		end

		// Pin levels are set on entry to a phase.
		if (do_enter) begin
			unique case (n_kind)
				i2cm_pkg::K_START: begin
					if (n_ph == 2'd0) begin
						n_sda = 1'b1;
						n_scl = 1'b1;
					end else if (n_ph == 2'd1) begin
						n_sda = 1'b0;
					end else begin
						n_scl = 1'b0;
					end
				end
				i2cm_pkg::K_STOP: begin
					if (n_ph == 2'd0) begin
						n_sda = 1'b0;
						n_scl = 1'b1;
					end else begin
						n_sda = 1'b1;
					end
				end
				i2cm_pkg::K_WRITE: begin
					if (n_bit < i2cm_pkg::ACK_SLOT) begin
						if (n_ph == 2'd0) begin
							n_sda = n_sout[7];
						end else if (n_ph == 2'd1) begin
							n_scl = 1'b1;
						end else begin
							n_scl  = 1'b0;
							if (n_bit == i2cm_pkg::LAST_BIT) begin
								n_sda = 1'b1;
							end
							n_sout = {n_sout[6:0], 1'b0};
						end
					end else begin
						if (n_ph == 2'd0) begin
							n_sda = 1'b1;
						end else if (n_ph == 2'd1) begin
							n_scl = 1'b1;
						end else begin
							n_scl = 1'b0;
						end
					end
				end
				i2cm_pkg::K_READ: begin
					if (n_bit < i2cm_pkg::ACK_SLOT) begin
						if (n_ph == 2'd0) begin
							n_scl = 1'b1;
							if (n_bit == '0) begin
								n_sda = 1'b1;
							end
						end else begin
							n_scl = 1'b0;
						end
					end else begin
						if (n_ph == 2'd0) begin
							n_sda = !n_want;
						end else if (n_ph == 2'd1) begin
							n_scl = 1'b1;
						end else begin
							n_scl = 1'b0;
						end
					end
				end
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			kind_q    <= i2cm_pkg::K_START;
			run_q     <= 1'b0;
			bit_q     <= '0;
			ph_q      <= '0;
			tick_q    <= '0;
			sout_q    <= '0;
			sin_q     <= '0;
			ack_q     <= 1'b0;
			scl_q     <= 1'b1;
			sda_q     <= 1'b1;
			want_q    <= 1'b0;
			done_q    <= 1'b0;
			res_vld_q <= 1'b0;
		end else begin
			if (pop) begin
				kind_q <= n_kind;
				run_q  <= n_run;
				bit_q  <= n_bit;
				ph_q   <= n_ph;
				tick_q <= n_tick;
				sout_q <= n_sout;
				sin_q  <= n_sin;
				ack_q  <= n_ack;
				scl_q  <= n_scl;
				sda_q  <= n_sda;
				want_q <= n_want;
				done_q <= n_done;
			end
			if (pop) begin
				res_vld_q <= 1'b1;
			end else if (res.ready) begin
				res_vld_q <= 1'b0;
			end
		end
	end

	// The state registers only move when a result is produced, so they are
	// the output payload directly.
	assign res.valid       = res_vld_q;
	assign res.scl_out     = scl_q;
	assign res.sda_out     = sda_q;
	assign res.busy_res    = run_q;
	assign res.done_res    = done_q;
	assign res.rx_byte     = sin_q;
	assign res.ack_missing = ack_q;

	a_bit_range: assert property (@(posedge clk) disable iff (!arst_n)
		bit_q <= i2cm_pkg::ACK_SLOT) else $error("bit slot past the ack slot");
	a_phase_range: assert property (@(posedge clk) disable iff (!arst_n)
		ph_q != 2'd3) else $error("phase index out of range");
	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> !run_q) else $error("done reported while still running");
	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(res_vld_q && !res.ready) |=> $stable(tick_q) && $stable(run_q))
		else $error("sequencer moved while its result was stalled");

endmodule

// ===== hdl/i2c_master_byte_engine.sv =====
// Top level of the I2C master byte engine: phase length register, front end,
// request queue and bit engine. Depends on i2cm_pkg, i2cm_if and the submodules.
//
//   channel | role   | accepted when          | carries
//   --------+--------+------------------------+----------------------------------
//   tick    | sink   | tick.valid & ready     | cmd_valid, action, tx_byte,
//           |        |                        | send_ack, sda_in
//   res     | source | res.valid & ready      | scl_out, sda_out, busy_res,
//           |        |                        | done_res, rx_byte, ack_missing
//   cfg     | sink   | cfg.valid & ready      | phase length in ticks (data)
//
// Every tick request yields exactly one result. The path runs through the
// front register, the queue and the engine's output register, in that order.
// With no stalls one request is taken and one result is given every cycle.
// The bit engine evaluates one tick per cycle while its result is not
// stalled; that single step sets the rate.
// Reset puts the bus lines released high, the engine idle and the phase
// length at ten ticks. A stalled result stops the engine, the queue then
// fills, and the front end drops ready once the queue and its own register
// are both occupied.
module i2c_master_byte_engine (
	input  logic       clk,
	input  logic       arst_n,
	i2cm_tick_if.sink  tick,
	i2cm_res_if.source res,
	i2cm_cfg_if.sink   cfg
);
	// The phase length is kept as its clamped value minus one, which is the
	// last tick index of a phase: zero acts as one, anything above the
	// maximum acts as the maximum.
	logic [i2cm_pkg::TICK_W-1:0] last_tick_q;
	logic [i2cm_pkg::PT_W-1:0]   data_m1;
	i2cm_pkg::q_stat_t           qstat;
	i2cm_pkg::q_entry_t          push_entry;
	i2cm_pkg::q_entry_t          head;
	logic                        push;
	logic                        pop;

	assign cfg.ready = 1'b1;
	assign data_m1   = cfg.data - 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_tick_q <= i2cm_pkg::TICK_W'(i2cm_pkg::RESET_TICKS - 1);
		end else if (cfg.valid && cfg.ready) begin
			if (cfg.data == '0) begin
				last_tick_q <= '0;
			end else if (cfg.data > i2cm_pkg::PT_W'(i2cm_pkg::MAX_PHASE_TICKS)) begin
				last_tick_q <= i2cm_pkg::TICK_W'(i2cm_pkg::MAX_PHASE_TICKS - 1);
			end else begin
				last_tick_q <= data_m1[i2cm_pkg::TICK_W-1:0];
			end
		end
	end

	// Front end: registers and decodes each tick request.
	i2cm_front u_front (
		.clk    (clk),
		.arst_n (arst_n),
		.tick   (tick),
		.qstat  (qstat),
		.push   (push),
		.entry  (push_entry)
	);

	// Queue that lets the front end keep taking requests while the engine
	// waits on a stalled result.
	i2cm_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_entry (push_entry),
		.pop        (pop),
		.head       (head),
		.qstat      (qstat)
	);

	// Bit engine with the output register.
	i2cm_engine u_engine (
		.clk       (clk),
		.arst_n    (arst_n),
		.head      (head),
		.qstat     (qstat),
		.last_tick (last_tick_q),
		.pop       (pop),
		.res       (res)
	);

endmodule
